[rtl/sida_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII unit.
// Used by sida_bcd_cell and signed_int_to_decimal_ascii_unit; no dependencies.
package sida_pkg;

    // Input word and BCD digit geometry
    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);
    localparam int CHAR_W     = 8;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SKIP,
        S_SIGN,
        S_EMIT
    } t_state;

    // Control broadcast to every digit cell
    typedef struct packed {
        logic clr;        // clear digit to zero
        logic dabble;     // add-3 adjust and shift one bit in from below
        logic shift_dig;  // take the whole digit of the lower neighbor
    } t_cell_ctl;

endpackage

[rtl/signed_int_to_decimal_ascii_unit.sv]
// Top level of the signed integer to decimal ASCII unit.
// Depends on sida_pkg and sida_bcd_cell.
//
// Converts one signed 32-bit request into its decimal text, one ASCII character per
// result, most significant digit first, no leading zeros, a leading '-' for negative
// values, and o_last set on the final character. The magnitude is shifted through a
// row of ten BCD digit cells (double dabble), one bit per cycle. The same row then
// shifts whole digits upward: leading zeros are dropped and the rest is presented at
// the top cell, one digit per character. A negative value emits the minus sign before
// the digits. A new request is taken only once the previous value has been fully
// emitted. One value is in flight at a time; output stalls hold the sign and emit
// states. o_stall is high while a value is being worked on.
module signed_int_to_decimal_ascii_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [sida_pkg::VALUE_W-1:0] i_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [sida_pkg::CHAR_W-1:0]         o_character,
    output logic                                o_last
);

    localparam int NumDigits = sida_pkg::NUM_DIGITS;
    localparam int ValueW    = sida_pkg::VALUE_W;

    sida_pkg::t_state              r_state;
    sida_pkg::t_state              n_state;
    logic [ValueW-1:0]             r_mag;
    logic                          r_neg;
    logic [sida_pkg::CNT_W-1:0]    r_cnt;
    logic [sida_pkg::REM_W-1:0]    r_rem;
    logic                          r_out_valid;
    logic [sida_pkg::CHAR_W-1:0]   r_char;
    logic                          r_last;

    sida_pkg::t_cell_ctl           w_ctl;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_emit;
    logic [sida_pkg::CHAR_W-1:0]   w_char;
    logic                          w_last;
    logic                          w_rem_dec;
    logic                          w_top_zero;
    logic                          w_rem_one;
    logic [sida_pkg::DIGIT_W-1:0]  w_digit [NumDigits];
    logic [sida_pkg::DIGIT_W-1:0]  w_top;

    // Handshake and status terms
    assign w_accept   = i_valid && (r_state == sida_pkg::S_IDLE);
    assign o_stall    = (r_state != sida_pkg::S_IDLE);
    assign w_out_free = !r_out_valid || !i_stall;
    assign w_top      = w_digit[NumDigits-1];
    assign w_top_zero = (w_top == '0);
    assign w_rem_one  = (r_rem == sida_pkg::REM_W'(1));

    // Row of BCD digit cells; cell 0 takes the next magnitude bit from below
    genvar gi;
    generate
        for (gi = 0; gi < NumDigits; gi++) begin : g_cell
            logic [sida_pkg::DIGIT_W-1:0] w_low;
            if (gi == 0) begin : g_first
                assign w_low = {r_mag[ValueW-1], {(sida_pkg::DIGIT_W-1){1'b0}}};
            end else begin : g_rest
                assign w_low = w_digit[gi-1];
            end
            sida_bcd_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_low_digit (w_low),
                .o_digit     (w_digit[gi])
            );
        end
    endgenerate

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sida_pkg::S_IDLE: begin
                if (i_valid) n_state = sida_pkg::S_CONV;
            end
            sida_pkg::S_CONV: begin
                if (r_cnt == sida_pkg::CNT_W'(ValueW - 1)) n_state = sida_pkg::S_SKIP;
            end
            sida_pkg::S_SKIP: begin
                if (!w_top_zero || w_rem_one) begin
                    n_state = r_neg ? sida_pkg::S_SIGN : sida_pkg::S_EMIT;
                end
            end
            sida_pkg::S_SIGN: begin
                if (w_out_free) n_state = sida_pkg::S_EMIT;
            end
            sida_pkg::S_EMIT: begin
                if (w_out_free && w_rem_one) n_state = sida_pkg::S_IDLE;
            end
            default: n_state = sida_pkg::S_IDLE;
        endcase
    end

    // State outputs: cell control and character issue
    always_comb begin
        w_ctl     = '0;
        w_emit    = 1'b0;
        w_char    = sida_pkg::CH_ZERO;
        w_last    = 1'b0;
        w_rem_dec = 1'b0;
        case (r_state)
            sida_pkg::S_IDLE: begin
                w_ctl.clr = w_accept;
            end
            sida_pkg::S_CONV: begin
                w_ctl.dabble = 1'b1;
            end
            sida_pkg::S_SKIP: begin
                if (w_top_zero && !w_rem_one) begin
                    w_ctl.shift_dig = 1'b1;
                    w_rem_dec       = 1'b1;
                end
            end
            sida_pkg::S_SIGN: begin
                w_emit = w_out_free;
                w_char = sida_pkg::CH_MINUS;
            end
            sida_pkg::S_EMIT: begin
                w_emit          = w_out_free;
                w_char          = sida_pkg::CH_ZERO +
                                  sida_pkg::CHAR_W'(w_top);
                w_last          = w_rem_one;
                w_ctl.shift_dig = w_out_free;
                w_rem_dec       = w_out_free;
            end
            default: begin
                w_ctl = '0;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sida_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load the magnitude, shift it out, and count bits and digits
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= i_value[ValueW-1];
            r_mag <= i_value[ValueW-1] ? (ValueW'(0) - ValueW'(i_value))
                                       : ValueW'(i_value);
            r_cnt <= '0;
            r_rem <= sida_pkg::REM_W'(NumDigits);
        end else begin
            if (r_state == sida_pkg::S_CONV) begin
                r_mag <= {r_mag[ValueW-2:0], 1'b0};
                r_cnt <= r_cnt + sida_pkg::CNT_W'(1);
            end
            if (w_rem_dec) begin
                r_rem <= r_rem - sida_pkg::REM_W'(1);
            end
        end
    end

    // Hold the output character
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> !(r_out_valid && i_stall))
        else $error("output register overwritten while stalled");

    a_emit_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sida_pkg::S_EMIT) |-> (r_rem != '0))
        else $error("emit with no digits remaining");

    a_top_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sida_pkg::S_EMIT) |-> (w_top <= sida_pkg::DIGIT_W'(9)))
        else $error("top cell holds a non-decimal digit");

    a_skip_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == sida_pkg::S_SKIP) && (n_state != sida_pkg::S_SKIP))
            |=> (!w_top_zero || w_rem_one))
        else $error("leading zero left in front of the digits");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_state == sida_pkg::S_IDLE))
        else $error("last character issued but the value is still in work");
`endif

endmodule

[rtl/sida_bcd_cell.sv]
// One BCD digit cell of the double-dabble chain.
// Depends on sida_pkg for the control struct and digit width.
module sida_bcd_cell (
    input  logic                          i_clk,
    input  sida_pkg::t_cell_ctl           i_ctl,
    input  logic [sida_pkg::DIGIT_W-1:0]  i_low_digit,
    output logic [sida_pkg::DIGIT_W-1:0]  o_digit
);

    logic [sida_pkg::DIGIT_W-1:0] r_digit;
    logic [sida_pkg::DIGIT_W-1:0] n_digit;
    logic [sida_pkg::DIGIT_W-1:0] w_adj;
    logic                         w_carry_in;

    // Add 3 when the digit would overflow past 9 after doubling
    assign w_adj      = (r_digit >= 4'd5) ? (r_digit + 4'd3) : r_digit;
    // The lower neighbor carries out when its digit is 5 or more
    assign w_carry_in = (i_low_digit >= 4'd5);

    // Select the next digit value
    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clr) begin
            n_digit = '0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[sida_pkg::DIGIT_W-2:0], w_carry_in};
        end else if (i_ctl.shift_dig) begin
            n_digit = i_low_digit;
        end
    end

    // Hold the digit
    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_digit = r_digit;

endmodule
